[sv/slt_pkg.sv]
package slt_pkg;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_BARE   = 2'd1,
    SCAN_QUOTED = 2'd2
  } scan_mode_e;

  // One classified request. With lit_bs set, a literal backslash goes out
  // ahead of the result that the remaining fields describe.
  typedef struct packed {
    logic       lit_bs;
    logic [7:0] ch;
    logic       has;
    logic       te;
    logic       le;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    is_quote = (c == ChDquote) || (c == ChSquote);
  endfunction

endpackage

[sv/shell_style_line_tokenizer_unit.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   char_in_i
// out      output     out_valid_o/out_stall_i char_out_o, has_char_o, token_end_o,
//                                             line_end_o, run_last_o
//
// One input byte is taken per cycle while the request queue has room.
// Each byte that gives results becomes one queue request; the output side
// drains one result per cycle while out_stall_i is low, so a byte with two
// results sends them in turn. Reset clears scanner state and empties the queue.
// A stall on the output fills the queue, after which in_stall_o rises.
module shell_style_line_tokenizer_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       has_char_o,
  output logic       token_end_o,
  output logic       line_end_o,
  output logic       run_last_o
);

  slt_pkg::cmd_t push_cmd;
  slt_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  slt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  slt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .has_char_o  (has_char_o),
    .token_end_o (token_end_o),
    .line_end_o  (line_end_o),
    .run_last_o  (run_last_o)
  );

endmodule

[sv/slt_front.sv]
module slt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     char_in_i,
  output logic           in_stall_o,
  input  logic           full_i,
  output logic           push_o,
  output slt_pkg::cmd_t  cmd_o
);

  slt_pkg::scan_mode_e mode_q, mode_d;
  logic                sq_q, sq_d;
  logic                bs_q, bs_d;

  logic                accept;
  logic                esc;
  logic                consumed;
  logic [7:0]          active;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign active     = sq_q ? slt_pkg::ChSquote : slt_pkg::ChDquote;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slt_pkg::SCAN_IDLE;
      sq_q   <= 1'b0;
      bs_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      sq_q   <= sq_d;
      bs_q   <= bs_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    sq_d     = sq_q;
    bs_d     = bs_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    consumed = 1'b0;
    esc      = 1'b0;
    if (accept) begin
      if (mode_q != slt_pkg::SCAN_BARE && mode_q != slt_pkg::SCAN_QUOTED) begin
        // Between tokens a pending backslash is meaningless and is cleared.
        bs_d = 1'b0;
        priority if (char_in_i == slt_pkg::ChNul) begin
          push_o   = 1'b1;
          cmd_o.le = 1'b1;
          mode_d   = slt_pkg::SCAN_IDLE;
          sq_d     = 1'b0;
        end else if (slt_pkg::is_ws(char_in_i)) begin
          mode_d = slt_pkg::SCAN_IDLE;
        end else if (slt_pkg::is_quote(char_in_i)) begin
          mode_d = slt_pkg::SCAN_QUOTED;
          sq_d   = (char_in_i == slt_pkg::ChSquote);
        end else if (char_in_i == slt_pkg::ChBslash) begin
          mode_d = slt_pkg::SCAN_BARE;
          bs_d   = 1'b1;
        end else begin
          mode_d    = slt_pkg::SCAN_BARE;
          push_o    = 1'b1;
          cmd_o.ch  = char_in_i;
          cmd_o.has = 1'b1;
        end
      end else begin
        if (bs_q) begin
          esc = (mode_q == slt_pkg::SCAN_BARE)
              ? (slt_pkg::is_quote(char_in_i) || char_in_i == slt_pkg::ChBslash ||
                 slt_pkg::is_ws(char_in_i))
              : (char_in_i == active || char_in_i == slt_pkg::ChBslash);
          bs_d = 1'b0;
          priority if (esc) begin
            push_o    = 1'b1;
            cmd_o.ch  = char_in_i;
            cmd_o.has = 1'b1;
            consumed  = 1'b1;
          end else if (char_in_i == slt_pkg::ChNul) begin
            // The held backslash itself closes the token and the line.
            push_o    = 1'b1;
            cmd_o.ch  = slt_pkg::ChBslash;
            cmd_o.has = 1'b1;
            cmd_o.te  = 1'b1;
            cmd_o.le  = 1'b1;
            mode_d    = slt_pkg::SCAN_IDLE;
            sq_d      = 1'b0;
            consumed  = 1'b1;
          end else begin
            cmd_o.lit_bs = 1'b1;
          end
        end
        if (!consumed) begin
          priority if (char_in_i == slt_pkg::ChNul) begin
            push_o   = 1'b1;
            cmd_o.te = 1'b1;
            cmd_o.le = 1'b1;
            mode_d   = slt_pkg::SCAN_IDLE;
            sq_d     = 1'b0;
            bs_d     = 1'b0;
          end else if (char_in_i == slt_pkg::ChBslash) begin
            bs_d = 1'b1;
          end else if (mode_q == slt_pkg::SCAN_BARE) begin
            push_o = 1'b1;
            priority if (slt_pkg::is_ws(char_in_i)) begin
              cmd_o.te = 1'b1;
              mode_d   = slt_pkg::SCAN_IDLE;
            end else if (slt_pkg::is_quote(char_in_i)) begin
              cmd_o.te = 1'b1;
              mode_d   = slt_pkg::SCAN_QUOTED;
              sq_d     = (char_in_i == slt_pkg::ChSquote);
            end else begin
              cmd_o.ch  = char_in_i;
              cmd_o.has = 1'b1;
            end
          end else begin
            push_o = 1'b1;
            if (char_in_i == active) begin
              cmd_o.te = 1'b1;
              mode_d   = slt_pkg::SCAN_IDLE;
              sq_d     = 1'b0;
            end else begin
              cmd_o.ch  = char_in_i;
              cmd_o.has = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

[sv/slt_queue.sv]
module slt_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slt_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output slt_pkg::cmd_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slt_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[sv/slt_back.sv]
module slt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  slt_pkg::cmd_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     char_out_o,
  output logic           has_char_o,
  output logic           token_end_o,
  output logic           line_end_o,
  output logic           run_last_o
);

  logic phase_q, phase_d;
  logic accept;
  logic first_bs;

  assign out_valid_o = !empty_i;
  assign accept      = out_valid_o && !out_stall_i;
  // A request with a literal backslash gives a backslash beat ahead of its own result.
  assign first_bs    = head_i.lit_bs && !phase_q;
  assign pop_o       = accept && !first_bs;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = first_bs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    if (first_bs) begin
      char_out_o  = slt_pkg::ChBslash;
      has_char_o  = 1'b1;
      token_end_o = 1'b0;
      line_end_o  = 1'b0;
      run_last_o  = 1'b0;
    end else begin
      char_out_o  = head_i.ch;
      has_char_o  = head_i.has;
      token_end_o = head_i.te;
      line_end_o  = head_i.le;
      run_last_o  = 1'b1;
    end
  end

endmodule

[sv/slt_checker.sv]
module slt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       has_char_o,
  input logic       token_end_o,
  input logic       line_end_o,
  input logic       run_last_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o) &&
      $stable(has_char_o) && $stable(token_end_o) && $stable(line_end_o) &&
      $stable(run_last_o))
    else $error("stalled result changed");

  // The end of a line is always the last result of its byte.
  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> run_last_o)
    else $error("line end not last result");

  // Only a literal backslash can precede a second result.
  a_first_is_bs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |->
      has_char_o && char_out_o == slt_pkg::ChBslash && !token_end_o && !line_end_o)
    else $error("bad leading result");

  // Results without a character carry a zero byte.
  a_no_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_char_o |-> char_out_o == slt_pkg::ChNul)
    else $error("nonzero byte without character");

  // A line end that carries a character also ends a token.
  a_le_char_te: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o && has_char_o |-> token_end_o)
    else $error("line end with character but no token end");

endmodule

bind shell_style_line_tokenizer_unit slt_checker u_slt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .char_out_o  (char_out_o),
  .has_char_o  (has_char_o),
  .token_end_o (token_end_o),
  .line_end_o  (line_end_o),
  .run_last_o  (run_last_o)
);
